### rtl/mtep_pkg.sv
// Package for the MIDI track event parser: parse phases, result record and
// the byte codes of the track format. No dependencies.
package mtep_pkg;

  // Width of a variable-length number as it is kept
  localparam int unsigned NUM_W  = 28;
  localparam int unsigned TICK_W = 32;

  // Byte codes of the track format
  localparam logic [7:0] DATA_MASK   = 8'h7F;
  localparam logic [7:0] NO_STATUS   = 8'h00;
  localparam logic [7:0] META_STATUS = 8'hFF;
  localparam logic [7:0] EOT_KIND    = 8'h2F;
  localparam logic [3:0] SYS_NIBBLE  = 4'hF;
  localparam logic [3:0] PROG_NIBBLE = 4'hC;
  localparam logic [3:0] PRES_NIBBLE = 4'hD;

  // Where the parser stands within the current event
  typedef enum logic [2:0] {
    PH_DELTA     = 3'd0,
    PH_STATUS    = 3'd1,
    PH_DATA1     = 3'd2,
    PH_DATA2     = 3'd3,
    PH_META_TYPE = 3'd4,
    PH_META_LEN  = 3'd5,
    PH_META_SKIP = 3'd6,
    PH_STOPPED   = 3'd7
  } phase_t;

  // One channel event as delivered on the result channel
  typedef struct packed {
    logic [7:0]        data_second;
    logic [7:0]        data_first;
    logic [7:0]        status;
    logic [TICK_W-1:0] tick;
  } event_t;

  // Channel statuses that carry a single data byte
  function automatic logic one_data_byte(input logic [7:0] st);
    return (st[7:4] == PROG_NIBBLE) || (st[7:4] == PRES_NIBBLE);
  endfunction

endpackage

### rtl/midi_track_event_parser.sv
// Top level of the MIDI track event parser: input byte register, parser
// core and result buffer. Depends on mtep_pkg, mtep_core, mtep_out_fifo.
//
//  channel  dir  handshake          tdata / tuser / tlast
//  in_      in   tvalid / tready    tdata[7:0] track byte, tlast chunk end
//  out_     out  tvalid / tready    tdata[55:0] tick, status, data 1, data 2
//
// One byte per cycle is taken while the buffer has room.
// Each byte's decision is one pass through the core between the input
// register and the two-entry result buffer.
// Reset (synchronous, active low) empties both stages and clears the state.
// A stalled result channel fills the buffer; input then stops until a slot
// frees.
module midi_track_event_parser #(
  parameter int unsigned MAX_NUMBER_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] track_byte
  input  logic        in_tlast,   // chunk_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // [31:0] event_tick, [39:32] event_status,
                                  // [47:40] event_data_first,
                                  // [55:48] event_data_second
);
  import mtep_pkg::*;

  logic       stg_vld_r;
  logic [7:0] stg_byte_r;
  logic       stg_last_r;
  logic       adv;
  logic       fifo_full;
  logic       res_vld;
  event_t     res;
  event_t     out_evt;

  // The registered byte moves on whenever the buffer has room
  assign adv       = stg_vld_r && !fifo_full;
  assign in_tready = !stg_vld_r || adv;

  // Input byte register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else if (in_tready) begin
      stg_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      stg_byte_r <= in_tdata;
      stg_last_r <= in_tlast;
    end
  end

  mtep_core #(
    .MAX_NUMBER_BYTES(MAX_NUMBER_BYTES)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (adv),
    .byte_in  (stg_byte_r),
    .byte_last(stg_last_r),
    .res_vld  (res_vld),
    .res      (res)
  );

  mtep_out_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_vld),
    .push_data(res),
    .full     (fifo_full),
    .pop_vld  (out_tvalid),
    .pop_rdy  (out_tready),
    .pop_data (out_evt)
  );

  assign out_tdata = {out_evt.data_second, out_evt.data_first,
                      out_evt.status, out_evt.tick};

endmodule

### rtl/mtep_core.sv
// Parser state and per-byte decision logic of the MIDI track event parser.
// Depends on mtep_pkg.
module mtep_core #(
  parameter int unsigned MAX_NUMBER_BYTES = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            byte_vld,   // a registered byte is handled this cycle
  input  logic [7:0]      byte_in,
  input  logic            byte_last,
  output logic            res_vld,
  output mtep_pkg::event_t res
);
  import mtep_pkg::*;

  localparam logic [2:0] MaxCnt = 3'(MAX_NUMBER_BYTES);

  phase_t            phase_r, phase_nxt;
  logic [7:0]        rs_r, rs_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [NUM_W-1:0]  acc_r, acc_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  logic [7:0]        held_r, held_nxt;
  logic [7:0]        kind_r, kind_nxt;
  logic [NUM_W-1:0]  skip_r, skip_nxt;

  logic [NUM_W-1:0]  num_acc;
  logic [2:0]        num_cnt;
  logic [NUM_W-1:0]  skip_dec;
  logic [7:0]        st;
  logic              is_st;

  // Next digit of a variable-length number, most significant group first
  assign num_acc  = {acc_r[NUM_W-8:0], byte_in[6:0]};
  assign num_cnt  = cnt_r + 3'd1;
  assign skip_dec = skip_r - NUM_W'(1);
  assign is_st    = byte_in[7];
  assign st       = is_st ? byte_in : rs_r;

  // Per-byte decision and result formation
  always_comb begin
    phase_nxt       = phase_r;
    rs_nxt          = rs_r;
    tick_nxt        = tick_r;
    acc_nxt         = acc_r;
    cnt_nxt         = cnt_r;
    held_nxt        = held_r;
    kind_nxt        = kind_r;
    skip_nxt        = skip_r;
    res_vld         = 1'b0;
    res.tick        = tick_r;
    res.status      = st;
    res.data_first  = byte_in;
    res.data_second = 8'h00;

    case (phase_r)
      PH_DELTA: begin
        acc_nxt = num_acc;
        cnt_nxt = num_cnt;
        if (!byte_in[7]) begin
          tick_nxt  = tick_r + TICK_W'(num_acc);
          acc_nxt   = '0;
          cnt_nxt   = '0;
          phase_nxt = PH_STATUS;
        end else if (num_cnt >= MaxCnt) begin
          phase_nxt = PH_STOPPED;
        end
      end
      PH_STATUS: begin
        rs_nxt = st;
        if (st == NO_STATUS) begin
          phase_nxt = PH_STOPPED;
        end else if (st == META_STATUS) begin
          if (is_st) begin
            phase_nxt = PH_META_TYPE;
          end else begin
            kind_nxt  = byte_in;
            acc_nxt   = '0;
            cnt_nxt   = '0;
            phase_nxt = PH_META_LEN;
          end
        end else if (st[7:4] == SYS_NIBBLE) begin
          phase_nxt = PH_DELTA;
          // A data byte under a system running status opens the next delta
          if (!is_st) begin
            acc_nxt = num_acc;
            cnt_nxt = num_cnt;
            if (!byte_in[7]) begin
              tick_nxt  = tick_r + TICK_W'(num_acc);
              acc_nxt   = '0;
              cnt_nxt   = '0;
              phase_nxt = PH_STATUS;
            end else if (num_cnt >= MaxCnt) begin
              phase_nxt = PH_STOPPED;
            end
          end
        end else if (is_st) begin
          phase_nxt = PH_DATA1;
        end else if (one_data_byte(st)) begin
          res_vld   = 1'b1;
          phase_nxt = PH_DELTA;
        end else begin
          held_nxt  = byte_in;
          phase_nxt = PH_DATA2;
        end
      end
      PH_DATA1: begin
        if (one_data_byte(rs_r)) begin
          res_vld    = 1'b1;
          res.status = rs_r;
          phase_nxt  = PH_DELTA;
        end else begin
          held_nxt  = byte_in;
          phase_nxt = PH_DATA2;
        end
      end
      PH_DATA2: begin
        res_vld         = 1'b1;
        res.status      = rs_r;
        res.data_first  = held_r;
        res.data_second = byte_in;
        phase_nxt       = PH_DELTA;
      end
      PH_META_TYPE: begin
        kind_nxt  = byte_in;
        acc_nxt   = '0;
        cnt_nxt   = '0;
        phase_nxt = PH_META_LEN;
      end
      PH_META_LEN: begin
        acc_nxt = num_acc;
        cnt_nxt = num_cnt;
        if (!byte_in[7] || (num_cnt >= MaxCnt)) begin
          if (kind_r == EOT_KIND) begin
            phase_nxt = PH_STOPPED;
          end else if (num_acc == '0) begin
            phase_nxt = PH_DELTA;
          end else begin
            skip_nxt  = num_acc;
            phase_nxt = PH_META_SKIP;
          end
          acc_nxt = '0;
          cnt_nxt = '0;
        end
      end
      PH_META_SKIP: begin
        skip_nxt = skip_dec;
        if (skip_dec == '0) begin
          phase_nxt = PH_DELTA;
        end
      end
      default: begin
      end
    endcase

    // At chunk end an unfinished channel event is flushed and all state clears
    if (byte_last) begin
      if (!res_vld && ((phase_nxt == PH_DATA1) || (phase_nxt == PH_DATA2))) begin
        res_vld         = 1'b1;
        res.status      = rs_nxt;
        res.data_first  = 8'h00;
        res.data_second = 8'h00;
      end
      phase_nxt = PH_DELTA;
      rs_nxt    = '0;
      tick_nxt  = '0;
      acc_nxt   = '0;
      cnt_nxt   = '0;
      held_nxt  = '0;
      kind_nxt  = '0;
      skip_nxt  = '0;
    end

    if (!byte_vld) begin
      res_vld = 1'b0;
    end
  end

  // Parser state registers, updated once per handled byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DELTA;
      rs_r    <= '0;
      tick_r  <= '0;
      acc_r   <= '0;
      cnt_r   <= '0;
      held_r  <= '0;
      kind_r  <= '0;
      skip_r  <= '0;
    end else if (byte_vld) begin
      phase_r <= phase_nxt;
      rs_r    <= rs_nxt;
      tick_r  <= tick_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      held_r  <= held_nxt;
      kind_r  <= kind_nxt;
      skip_r  <= skip_nxt;
    end
  end

  // A handled last byte leaves the parser waiting for a delta time
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    byte_vld && byte_last |=> (phase_r == PH_DELTA) && (tick_r == '0) && (rs_r == '0))
    else $error("state not cleared after chunk end");

  // Stopped parsing never yields an event
  a_stopped_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_STOPPED) |-> !res_vld)
    else $error("event produced while stopped");

  // A number byte count never reaches past the configured limit
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MaxCnt)
    else $error("number byte count overran");

endmodule

### rtl/mtep_out_fifo.sv
// Two-entry result buffer that parts the parser from the result channel.
// Depends on mtep_pkg.
module mtep_out_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mtep_pkg::event_t push_data,
  output logic             full,
  output logic             pop_vld,
  input  logic             pop_rdy,
  output mtep_pkg::event_t pop_data
);
  import mtep_pkg::*;

  event_t     mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       pop;

  assign full     = (cnt_r == 2'd2);
  assign pop_vld  = (cnt_r != 2'd0);
  assign pop      = pop_vld && pop_rdy;
  assign pop_data = mem_r[rd_ptr_r];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full result buffer");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result buffer count out of range");

  a_ptr_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> (wr_ptr_r == rd_ptr_r))
    else $error("result buffer pointers disagree with count");

endmodule
